// ===== design/led_strobe_and_fade_channel_core_macros.svh =====
// Assertion macros used by the LED channel core.
// Depends on nothing; users must have clk and arst_n in scope.
`ifndef LED_STROBE_AND_FADE_CHANNEL_CORE_MACROS_SVH
`define LED_STROBE_AND_FADE_CHANNEL_CORE_MACROS_SVH

// Clocked property checked outside reset.
`define LSF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define LSF_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== design/lsf_pkg.sv =====
// Package for the LED strobe and fade channel: modes, register indexes,
// constants and the structs passed between the channel modules. No dependencies.
package lsf_pkg;

	typedef enum logic [1:0] {
		MODE_OFF      = 2'd0,
		MODE_BLINK    = 2'd1,
		MODE_FADE     = 2'd2,
		MODE_SWITCHED = 2'd3
	} mode_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEPS     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DURATION  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd4;

	localparam logic [7:0]  RST_STEPS     = 8'd1;
	localparam logic [15:0] RST_PERIOD    = 16'd1000;
	localparam logic [15:0] RST_DURATION  = 16'd1000;
	localparam logic [15:0] RST_THRESHOLD = 16'd0;

	localparam logic [7:0] LEVEL_ON  = 8'd255;
	localparam logic [7:0] LEVEL_OFF = 8'd0;

	// Beacon phase codes held in the shared phase register.
	localparam logic [8:0] FADE_RISE = 9'd0;
	localparam logic [8:0] FADE_FALL = 9'd1;
	localparam logic [8:0] FADE_HOLD = 9'd2;

	localparam logic signed [10:0] FADE_MAX = 11'sd511;
	localparam logic signed [10:0] FADE_MIN = -11'sd512;
	localparam logic signed [10:0] FADE_TOP = 11'sd255;

	typedef struct packed {
		mode_t       mode;
		logic [7:0]  step_count;
		logic [15:0] period_ms;
		logic [15:0] duration_ms;
		logic [15:0] pulse_threshold;
		logic [15:0] burst_gap;
	} cfg_t;

	typedef struct packed {
		logic [31:0]        last_time;
		logic [8:0]         phase;
		logic signed [9:0]  fade_level;
	} chan_state_t;

	typedef struct packed {
		logic        update;
		logic        analog_drive;
		logic [7:0]  level;
		chan_state_t nxt;
	} tick_res_t;

endpackage

// ===== design/lsf_cfg_regs.sv =====
// Configuration registers of the LED channel plus the registered burst gap.
// Depends on lsf_pkg.
module lsf_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lsf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lsf_pkg::CFG_DATA_W-1:0] cfg_data,
	output lsf_pkg::cfg_t                   cfg
);
	import lsf_pkg::*;

	mode_t       mode_q;
	logic [7:0]  steps_q;
	logic [15:0] period_q;
	logic [15:0] duration_q;
	logic [15:0] threshold_q;
	logic [15:0] gap_q;

	logic [7:0]  steps_m1;
	logic [23:0] half_burst;
	logic [24:0] burst;
	logic [15:0] gap_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_OFF;
			steps_q     <= RST_STEPS;
			period_q    <= RST_PERIOD;
			duration_q  <= RST_DURATION;
			threshold_q <= RST_THRESHOLD;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:      mode_q      <= mode_t'(cfg_data[1:0]);
				REG_STEPS:     steps_q     <= cfg_data[7:0];
				REG_PERIOD:    period_q    <= cfg_data;
				REG_DURATION:  duration_q  <= cfg_data;
				REG_THRESHOLD: threshold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The burst covers every flash half but the last pair; what remains of
	// the period is the gap, floored at zero.
	always_comb begin
		steps_m1   = (steps_q == 8'd0) ? 8'd0 : steps_q - 8'd1;
		half_burst = steps_m1 * duration_q;
		burst      = {half_burst, 1'b0};
		gap_d      = ({9'd0, period_q} > burst) ? period_q - burst[15:0] : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= RST_PERIOD;
		end else begin
			gap_q <= gap_d;
		end
	end

	assign cfg = '{mode: mode_q, step_count: steps_q, period_ms: period_q,
		duration_ms: duration_q, pulse_threshold: threshold_q, burst_gap: gap_q};

endmodule

// ===== design/lsf_blink.sv =====
// Strobe blinker tick logic: next state and drive for one tick.
// Depends on lsf_pkg.
module lsf_blink (
	input  lsf_pkg::cfg_t        cfg,
	input  lsf_pkg::chan_state_t st,
	input  logic [31:0]          now_ms,
	input  logic [15:0]          pulse_width,
	output lsf_pkg::tick_res_t   res
);
	import lsf_pkg::*;

	logic [31:0] elapsed;
	logic [8:0]  ph;
	logic        fire;

	always_comb begin
		elapsed = now_ms - st.last_time;
		// Past the gap the burst restarts, but the time mark stays.
		ph   = (elapsed > {16'd0, cfg.burst_gap}) ? 9'd0 : st.phase;
		fire = (ph < {cfg.step_count, 1'b0}) && (elapsed > {16'd0, cfg.duration_ms});

		res              = '0;
		res.nxt          = st;
		res.nxt.phase    = ph;
		if (fire) begin
			res.update        = 1'b1;
			res.level         = (!ph[0] && (pulse_width > cfg.pulse_threshold)) ?
				LEVEL_ON : LEVEL_OFF;
			res.nxt.last_time = now_ms;
			res.nxt.phase     = ph + 9'd1;
		end
	end

endmodule

// ===== design/lsf_fade.sv =====
// Fading beacon tick logic: ramp up, ramp down, hold at zero until the period is up, then ramp up again.
// Depends on lsf_pkg.
module lsf_fade (
	input  lsf_pkg::cfg_t        cfg,
	input  lsf_pkg::chan_state_t st,
	input  logic [31:0]          now_ms,
	output lsf_pkg::tick_res_t   res
);
	import lsf_pkg::*;

	logic [31:0]        elapsed;
	logic signed [10:0] cur;
	logic signed [10:0] stp;
	logic signed [10:0] sum;
	logic signed [10:0] sat;

	always_comb begin
		elapsed = now_ms - st.last_time;
		cur     = {st.fade_level[9], st.fade_level};
		stp     = {3'b000, cfg.step_count};
		sum     = (st.phase == FADE_RISE) ? cur + stp : cur - stp;
		if (sum > FADE_MAX) begin
			sat = FADE_MAX;
		end else if (sum < FADE_MIN) begin
			sat = FADE_MIN;
		end else begin
			sat = sum;
		end

		res     = '0;
		res.nxt = st;
		if ((st.phase < FADE_HOLD) && (elapsed >= {16'd0, cfg.duration_ms})) begin
			res.update         = 1'b1;
			res.analog_drive   = 1'b1;
			// The stored level may run past the PWM range; the drive is clipped.
			if (sat < 11'sd0) begin
				res.level = LEVEL_OFF;
			end else if (sat > FADE_TOP) begin
				res.level = LEVEL_ON;
			end else begin
				res.level = sat[7:0];
			end
			res.nxt.fade_level = sat[9:0];
			res.nxt.last_time  = now_ms;
			if (sat >= FADE_TOP) begin
				res.nxt.phase = FADE_FALL;
			end
			if (sat <= 11'sd0) begin
				res.nxt.phase = FADE_HOLD;
			end
		end else if ((st.phase == FADE_HOLD) && (elapsed >= {16'd0, cfg.period_ms})) begin
			res.nxt.last_time = now_ms;
			res.nxt.phase     = FADE_RISE;
		end
	end

endmodule

// ===== design/led_strobe_and_fade_channel_core.sv =====
// LED strobe and fade channel core: one result item per accepted tick item.
// Path: an item taken on s_axis waits in the input register while the output
// register is full and not being emptied, then moves into it and is offered on m_axis.
// Throughput: one item per cycle while m_axis does not stall, bounded by the
// channel state update, which runs combinationally from the state registers back into them.
// Reset: arst_n clears the stage valids and channel state, loads register defaults.
module led_strobe_and_fade_channel_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// Tick input: tdata bits 31:0 now_ms, bits 47:32 pulse_width.
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [47:0]                     s_axis_tdata,
	// Drive output: tdata bit 0 update, bit 1 analog_drive, bits 9:2 level,
	// bits 15:10 zero.
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [15:0]                     m_axis_tdata,
	// Configuration write port.
	input  logic                            cfg_we,
	input  logic [lsf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lsf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lsf_pkg::*;
	`include "led_strobe_and_fade_channel_core_macros.svh"

	cfg_t cfg;

	// Input register stage.
	logic        valid_s1;
	logic [31:0] now_s1;
	logic [15:0] pw_s1;

	// Channel state, carried from one tick to the next.
	chan_state_t state_q;

	// Output register.
	logic        out_valid_q;
	logic        update_q;
	logic        analog_q;
	logic [7:0]  level_q;

	tick_res_t blink_res;
	tick_res_t fade_res;
	tick_res_t idle_res;
	tick_res_t res;
	logic      advance;

	lsf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lsf_blink u_blink (
		.cfg         (cfg),
		.st          (state_q),
		.now_ms      (now_s1),
		.pulse_width (pw_s1),
		.res         (blink_res)
	);

	lsf_fade u_fade (
		.cfg    (cfg),
		.st     (state_q),
		.now_ms (now_s1),
		.res    (fade_res)
	);

	// The item in the input register moves on when the output register is
	// empty or is being emptied in this cycle. The input register in turn
	// takes a new item whenever it is empty or moving on.
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			now_s1 <= s_axis_tdata[31:0];
			pw_s1  <= s_axis_tdata[47:32];
		end
	end

	// Mode select. An unused mode, or a switched beacon whose pulse is not
	// above the threshold, leaves the state alone and writes nothing.
	always_comb begin
		idle_res     = '0;
		idle_res.nxt = state_q;
		case (cfg.mode)
			MODE_BLINK:    res = blink_res;
			MODE_FADE:     res = fade_res;
			MODE_SWITCHED: res = (pw_s1 > cfg.pulse_threshold) ? fade_res : idle_res;
			default:       res = idle_res;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= res.nxt;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			update_q <= res.update;
			analog_q <= res.analog_drive;
			level_q  <= res.level;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, level_q, analog_q, update_q};

	// A processed item always lands in the output register.
	`LSF_ASSERT(a_advance_fills_out, advance |=> m_axis_tvalid, "processed item lost")
	// A result without a write carries a zero drive.
	`LSF_ASSERT(a_no_write_is_zero,
		(m_axis_tvalid && !update_q) |-> (!analog_q && level_q == LEVEL_OFF),
		"drive fields set without a write")
	// Digital writes are full on or full off.
	`LSF_ASSERT(a_digital_levels,
		(m_axis_tvalid && update_q && !analog_q) |->
		(level_q == LEVEL_ON || level_q == LEVEL_OFF),
		"digital write with a partial level")
	// PWM writes come only from the beacon modes.
	`LSF_NEVER(a_analog_only_fade, advance && res.analog_drive && !cfg.mode[1],
		"PWM write outside beacon mode")

endmodule
